>>> hw/rtl/mss_pkg.sv
// Package with widths, status codes and shared types of the Markov stationary solver.
`default_nettype none
package mss_pkg;
  localparam int FRAC_BITS = 16;
  localparam int IN_W = 17;
  localparam int OUT_W = 17;
  localparam int A_W = IN_W + 1;
  localparam int PROD_W = 2 * A_W;
  localparam int C_W = PROD_W + 1;
  localparam int D_W = C_W + 2;
  localparam int MAG_W = D_W;
  localparam int QW = FRAC_BITS + 2;
  localparam logic [IN_W:0] ONE = (IN_W + 1)'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_CLAMPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [MAG_W-1:0] num;
    logic neg;
    logic zero;
  } lane_t;

  typedef struct packed {
    logic [MAG_W-1:0] dmag;
    logic dneg;
    logic singular;
  } den_t;
endpackage
`default_nettype wire

>>> hw/rtl/markov_stationary_solver_3state_top.sv
// Top level of the three-state Markov stationary distribution solver.
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_p_from*_to*
// out      output     out_valid, out_ready, out_pi_state*, out_solve_status
// One word enters per cycle while the output is not stalled. The pipeline
// has three cofactor stages, a load stage, one divider stage per quotient bit
// (FRAC_BITS + 1) and the output register.
// Reset clears all valid bits. A stall on the output holds the whole pipeline
// while the output register is full.
`default_nettype none
module markov_stationary_solver_3state_top (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [16:0] in_p_from0_to0,
  input wire logic [16:0] in_p_from0_to1,
  input wire logic [16:0] in_p_from1_to0,
  input wire logic [16:0] in_p_from1_to1,
  input wire logic [16:0] in_p_from2_to0,
  input wire logic [16:0] in_p_from2_to1,
  output logic out_valid,
  input wire logic out_ready,
  output logic [16:0] out_pi_state0,
  output logic [16:0] out_pi_state1,
  output logic [16:0] out_pi_state2,
  output logic [1:0] out_solve_status
);
  logic adv, cf_vld, dv_vld;
  mss_pkg::lane_t lanes [3];
  mss_pkg::den_t den;
  logic [mss_pkg::OUT_W-1:0] pi [3];
  mss_pkg::status_t st;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  mss_cofactor u_cof (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid),
    .p00(in_p_from0_to0), .p01(in_p_from0_to1), .p10(in_p_from1_to0),
    .p11(in_p_from1_to1), .p20(in_p_from2_to0), .p21(in_p_from2_to1),
    .out_vld(cf_vld), .lane_o(lanes), .den_o(den)
  );

  mss_divider u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(cf_vld), .lane_i(lanes),
    .den_i(den), .out_vld(dv_vld), .pi_o(pi), .status_o(st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pi_state0 <= pi[0];
      out_pi_state1 <= pi[1];
      out_pi_state2 <= pi[2];
      out_solve_status <= st;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/mss_cofactor.sv
// Cofactor and determinant stages of the Markov stationary solver.
`default_nettype none
module mss_cofactor (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic adv,
  input wire logic in_vld,
  input wire logic [mss_pkg::IN_W-1:0] p00,
  input wire logic [mss_pkg::IN_W-1:0] p01,
  input wire logic [mss_pkg::IN_W-1:0] p10,
  input wire logic [mss_pkg::IN_W-1:0] p11,
  input wire logic [mss_pkg::IN_W-1:0] p20,
  input wire logic [mss_pkg::IN_W-1:0] p21,
  output logic out_vld,
  output mss_pkg::lane_t lane_o [3],
  output mss_pkg::den_t den_o
);
  logic signed [mss_pkg::A_W-1:0] a00, a10, a01, a11, a02, a12;
  logic signed [mss_pkg::PROD_W-1:0] pr_r [6];
  logic signed [mss_pkg::C_W-1:0] c_r [3];
  logic v1_r, v2_r, v3_r;
  logic signed [mss_pkg::D_W-1:0] d;
  logic signed [mss_pkg::D_W-1:0] ce [3];

  assign a00 = $signed({1'b0, p00}) - $signed(mss_pkg::ONE);
  assign a10 = $signed({1'b0, p01});
  assign a01 = $signed({1'b0, p10});
  assign a11 = $signed({1'b0, p11}) - $signed(mss_pkg::ONE);
  assign a02 = $signed({1'b0, p20});
  assign a12 = $signed({1'b0, p21});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r[0] <= a01 * a12;
      pr_r[1] <= a02 * a11;
      pr_r[2] <= a02 * a10;
      pr_r[3] <= a00 * a12;
      pr_r[4] <= a00 * a11;
      pr_r[5] <= a01 * a10;
      c_r[0] <= mss_pkg::C_W'(pr_r[0]) - mss_pkg::C_W'(pr_r[1]);
      c_r[1] <= mss_pkg::C_W'(pr_r[2]) - mss_pkg::C_W'(pr_r[3]);
      c_r[2] <= mss_pkg::C_W'(pr_r[4]) - mss_pkg::C_W'(pr_r[5]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) ce[i] = mss_pkg::D_W'(c_r[i]);
    d = ce[0] + ce[1] + ce[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        lane_o[i].neg <= ce[i][mss_pkg::D_W-1];
        lane_o[i].zero <= (ce[i] == '0);
        lane_o[i].num <= ce[i][mss_pkg::D_W-1] ? mss_pkg::MAG_W'(-ce[i]) :
                         mss_pkg::MAG_W'(ce[i]);
      end
      den_o.dneg <= d[mss_pkg::D_W-1];
      den_o.singular <= (d == '0);
      den_o.dmag <= d[mss_pkg::D_W-1] ? mss_pkg::MAG_W'(-d) : mss_pkg::MAG_W'(d);
    end
  end

  assign out_vld = v3_r;
endmodule
`default_nettype wire

>>> hw/rtl/mss_divider.sv
// Pipelined restoring divider stages, one quotient bit per stage.
`default_nettype none
module mss_divider (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic adv,
  input wire logic in_vld,
  input wire mss_pkg::lane_t lane_i [3],
  input wire mss_pkg::den_t den_i,
  output logic out_vld,
  output logic [mss_pkg::OUT_W-1:0] pi_o [3],
  output mss_pkg::status_t status_o
);
  localparam int NS = mss_pkg::FRAC_BITS + 1;
  localparam int RW = mss_pkg::MAG_W + 1;
  logic [RW-1:0] rem_r [NS+1][3];
  logic [mss_pkg::QW-1:0] q_r [NS+1][3];
  logic big_r [NS+1][3];
  mss_pkg::den_t den_r [NS+1];
  logic neg_r [NS+1][3];
  logic zero_r [NS+1][3];
  logic [NS:0] v_r;
  logic [RW-1:0] sh [NS][3];
  logic ge [NS][3];
  logic [mss_pkg::QW-1:0] qf [3];
  logic cl [3];
  logic [mss_pkg::OUT_W-1:0] pv [3];
  logic anycl;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-1:0], in_vld};
  end

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 3; l++) begin
        sh[s][l] = (s == 0) ? rem_r[0][l] : {rem_r[s][l][RW-2:0], 1'b0};
        ge[s][l] = sh[s][l] >= RW'(den_r[s].dmag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= den_i;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= RW'(lane_i[l].num);
        q_r[0][l] <= '0;
        big_r[0][l] <= 1'b0;
        neg_r[0][l] <= lane_i[l].neg;
        zero_r[0][l] <= lane_i[l].zero;
      end
      for (int s = 0; s < NS; s++) begin
        den_r[s+1] <= den_r[s];
        for (int l = 0; l < 3; l++) begin
          neg_r[s+1][l] <= neg_r[s][l];
          zero_r[s+1][l] <= zero_r[s][l];
          if (s == 0) begin
            big_r[1][l] <= {1'b0, sh[0][l]} >= {RW'(den_r[0].dmag), 1'b0};
          end else begin
            big_r[s+1][l] <= big_r[s][l];
          end
          rem_r[s+1][l] <= ge[s][l] ? sh[s][l] - RW'(den_r[s].dmag) : sh[s][l];
          q_r[s+1][l] <= {q_r[s][l][mss_pkg::QW-2:0], ge[s][l]};
        end
      end
    end
  end

  always_comb begin
    anycl = 1'b0;
    for (int l = 0; l < 3; l++) begin
      qf[l] = q_r[NS][l];
      cl[l] = 1'b0;
      pv[l] = '0;
      if (zero_r[NS][l]) begin
        pv[l] = '0;
      end else if (neg_r[NS][l] != den_r[NS].dneg) begin
        cl[l] = 1'b1;
      end else if (big_r[NS][l] || qf[l] > mss_pkg::QW'(mss_pkg::ONE)) begin
        cl[l] = 1'b1;
        pv[l] = mss_pkg::OUT_W'(mss_pkg::ONE);
      end else begin
        pv[l] = mss_pkg::OUT_W'(qf[l]);
      end
      if (den_r[NS].singular) begin
        pv[l] = '0;
        cl[l] = 1'b0;
      end
      anycl = anycl | cl[l];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) pi_o[l] = pv[l];
    if (den_r[NS].singular) status_o = mss_pkg::ST_SINGULAR;
    else if (anycl) status_o = mss_pkg::ST_CLAMPED;
    else status_o = mss_pkg::ST_OK;
  end

  assign out_vld = v_r[NS];
endmodule
`default_nettype wire

>>> hw/rtl/mss_checker.sv
// Port checker for the Markov stationary solver, bound to the top level.
`default_nettype none
module mss_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [16:0] out_pi_state0,
  input wire logic [1:0] out_solve_status
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pi_state0))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stall");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_solve_status != 2'd3)
    else $error("bad status");
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_solve_status == mss_pkg::ST_SINGULAR |-> out_pi_state0 == 17'd0)
    else $error("singular word with nonzero value");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pi_state0 <= 17'h10000)
    else $error("value above one");
endmodule

bind markov_stationary_solver_3state_top mss_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_pi_state0(out_pi_state0),
  .out_solve_status(out_solve_status)
);
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the three-state Markov stationary solver: random and directed matrices checked against a local predictor.
`default_nettype none
module tb_top;

  typedef struct {
    logic [16:0] pi0;
    logic [16:0] pi1;
    logic [16:0] pi2;
    mss_pkg::status_t st;
  } solution_t;

  class solution_board;
    solution_t pending[$];
    int mismatches;
    int checked;
    int singular_seen;
    int clamped_seen;

    function logic [16:0] divide_lane(longint c, longint d, ref bit clamped);
      longint unsigned cm, dm, q, r, one;
      one = 64'd1 << mss_pkg::FRAC_BITS;
      cm = (c < 0) ? -c : c;
      dm = (d < 0) ? -d : d;
      if (cm == 0) return 17'd0;
      if ((c < 0) != (d < 0)) begin
        clamped = 1;
        return 17'd0;
      end
      q = cm / dm;
      if (q >= 2) begin
        clamped = 1;
        return one[16:0];
      end
      r = cm - q * dm;
      for (int i = 0; i < mss_pkg::FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= dm) begin
          r = r - dm;
          q = q | 1;
        end
      end
      if (q > one) begin
        clamped = 1;
        return one[16:0];
      end
      return q[16:0];
    endfunction

    function void note_matrix(logic [16:0] p00, logic [16:0] p01, logic [16:0] p10,
                              logic [16:0] p11, logic [16:0] p20, logic [16:0] p21);
      longint one, a00, a10, a01, a11, a02, a12, c0, c1, c2, d;
      bit clamped;
      solution_t s;
      one = longint'(1) << mss_pkg::FRAC_BITS;
      a00 = longint'(p00) - one;
      a10 = longint'(p01);
      a01 = longint'(p10);
      a11 = longint'(p11) - one;
      a02 = longint'(p20);
      a12 = longint'(p21);
      c0 = a01 * a12 - a02 * a11;
      c1 = a02 * a10 - a00 * a12;
      c2 = a00 * a11 - a01 * a10;
      d = c0 + c1 + c2;
      clamped = 0;
      if (d == 0) begin
        s.pi0 = 0;
        s.pi1 = 0;
        s.pi2 = 0;
        s.st = mss_pkg::ST_SINGULAR;
      end else begin
        s.pi0 = divide_lane(c0, d, clamped);
        s.pi1 = divide_lane(c1, d, clamped);
        s.pi2 = divide_lane(c2, d, clamped);
        s.st = clamped ? mss_pkg::ST_CLAMPED : mss_pkg::ST_OK;
      end
      pending.push_back(s);
    endfunction

    function void check_solution(logic [16:0] pi0, logic [16:0] pi1, logic [16:0] pi2,
                                 logic [1:0] st);
      solution_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output word %h %h %h %0d", pi0, pi1, pi2, st);
        return;
      end
      e = pending.pop_front();
      if (e.st == mss_pkg::ST_SINGULAR) singular_seen++;
      if (e.st == mss_pkg::ST_CLAMPED) clamped_seen++;
      if (pi0 !== e.pi0 || pi1 !== e.pi1 || pi2 !== e.pi2 || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h %h %h %0d, got %h %h %h %0d",
                   e.pi0, e.pi1, e.pi2, e.st, pi0, pi1, pi2, st);
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  logic [16:0] in_p_from0_to0, in_p_from0_to1, in_p_from1_to0;
  logic [16:0] in_p_from1_to1, in_p_from2_to0, in_p_from2_to1;
  logic [16:0] out_pi_state0, out_pi_state1, out_pi_state2;
  logic [1:0] out_solve_status;
  solution_board board;
  int cycles;
  int stall_mode;

  markov_stationary_solver_3state_top u_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Timeout after %0d cycles", cycles);
        $display("FAIL markov_stationary_solver_3state_top");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_solution(out_pi_state0, out_pi_state1, out_pi_state2, out_solve_status);
  end

  always @(posedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((cycles % 7) < 4);
    endcase
  end

  always @(posedge clk) begin
    if ((cycles % 200) == 0) stall_mode <= $urandom_range(0, 3);
  end

  function automatic logic [16:0] rand_prob();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'h1FFFF;
      3: return 17'($urandom_range(0, 17'h1FFFF));
      default: return 17'($urandom_range(0, 17'h10000));
    endcase
  endfunction

  task automatic send_matrix(logic [16:0] p00, logic [16:0] p01, logic [16:0] p10,
                             logic [16:0] p11, logic [16:0] p20, logic [16:0] p21);
    in_valid <= 1'b1;
    in_p_from0_to0 <= p00;
    in_p_from0_to1 <= p01;
    in_p_from1_to0 <= p10;
    in_p_from1_to1 <= p11;
    in_p_from2_to0 <= p20;
    in_p_from2_to1 <= p21;
    do @(posedge clk); while (!in_ready);
    board.note_matrix(p00, p01, p10, p11, p20, p21);
  endtask

  task automatic send_stochastic();
    logic [16:0] r[6];
    int a, b;
    for (int row = 0; row < 3; row++) begin
      a = $urandom_range(0, 65536);
      b = $urandom_range(0, 65536 - a);
      r[2 * row] = 17'(a);
      r[2 * row + 1] = 17'(b);
    end
    send_matrix(r[0], r[1], r[2], r[3], r[4], r[5]);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int burst, sent;
    board = new();
    stall_mode = 0;
    rst_n = 0;
    in_valid = 0;
    out_ready = 1;
    in_p_from0_to0 = 0;
    in_p_from0_to1 = 0;
    in_p_from1_to0 = 0;
    in_p_from1_to1 = 0;
    in_p_from2_to0 = 0;
    in_p_from2_to1 = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_matrix(0, 0, 0, 0, 0, 0);
    send_matrix(17'h10000, 0, 0, 17'h10000, 0, 0);
    send_matrix(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_matrix(17'h08000, 17'h08000, 17'h08000, 17'h08000, 17'h08000, 17'h08000);
    send_matrix(17'h05555, 17'h05555, 17'h05555, 17'h05555, 17'h05555, 17'h05555);
    send_matrix(0, 17'h10000, 0, 0, 17'h10000, 0);
    send_matrix(17'h04000, 17'h04000, 17'h02000, 17'h0C000, 17'h08000, 17'h04000);
    send_matrix(17'h10000, 0, 17'h10000, 0, 17'h10000, 0);
    send_matrix(0, 17'h10000, 0, 17'h10000, 0, 17'h10000);
    send_matrix(17'h1FFFF, 0, 0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_matrix(17'h0FFFF, 17'h00001, 17'h00001, 17'h0FFFF, 17'h00001, 17'h00001);
    send_matrix(17'h1A000, 17'h03000, 17'h11111, 17'h0AAAA, 17'h00000, 17'h1FFFF);
    send_matrix(17'h00001, 17'h00000, 17'h00000, 17'h00001, 17'h10000, 17'h10000);

    sent = 0;
    while (sent < 1150) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if ($urandom_range(0, 4) != 0) send_stochastic();
        else send_matrix(rand_prob(), rand_prob(), rand_prob(), rand_prob(), rand_prob(),
                         rand_prob());
        sent++;
      end
      idle_gap();
    end
    in_valid <= 1'b0;

    stall_mode = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (mss_pkg::FRAC_BITS + 10) @(posedge clk);
    $display("Checked %0d solutions, %0d singular and %0d clamped, over %0d cycles.",
             board.checked, board.singular_seen, board.clamped_seen, cycles);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("PASS markov_stationary_solver_3state_top");
    else begin
      $display("%0d mismatches", board.mismatches);
      $display("FAIL markov_stationary_solver_3state_top");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> markov_stationary_solver_3state_top.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_cofactor.sv
hw/rtl/mss_divider.sv
hw/rtl/markov_stationary_solver_3state_top.sv
hw/rtl/mss_checker.sv
tb/sv/tb_top.sv
